[hw/rtl/arc_pkg.sv]
// ----------------------------------------------------------------------------
// arc_pkg
// Shared sizes, codes and types of the ARP resolution cache.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned POOL    = 16;
  localparam int unsigned EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PW      = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int unsigned PCW     = $clog2(POOL + 1);

  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  typedef enum logic [2:0] {
    REG_OWN_IP        = 3'd0,
    REG_OWN_MAC       = 3'd1,
    REG_RETRY_TIMEOUT = 3'd2,
    REG_RETRY_LIMIT   = 3'd3,
    REG_CACHE_TIMEOUT = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    FUNC_OUTBOUND = 2'd0,
    FUNC_RECEIVED = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_SEND  = 3'd0,
    KIND_REQ   = 3'd1,
    KIND_REPLY = 3'd2,
    KIND_FAIL  = 3'd3,
    KIND_FULL  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DISPATCH,
    ST_RX_ANSWER,
    ST_TICK_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [15:0]   handle;
    logic [EW-1:0] owner;
  } pool_ent_t;

  typedef struct packed {
    logic load;
    logic shift;
  } pool_ctl_t;

endpackage

[hw/rtl/arc_pool_cell.sv]
// ----------------------------------------------------------------------------
// arc_pool_cell
// One slot of the queued-handle chain; loads a new item or takes its
// downstream neighbor's item when a slot below it is removed.
// ----------------------------------------------------------------------------
module arc_pool_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arc_pkg::pool_ctl_t ctl_i,
  input  arc_pkg::pool_ent_t wr_i,
  input  arc_pkg::pool_ent_t nb_i,
  output arc_pkg::pool_ent_t q_o
);

  arc_pkg::pool_ent_t ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (ctl_i.load) begin
      ent_q <= wr_i;
    end else if (ctl_i.shift) begin
      ent_q <= nb_i;
    end
  end

  assign q_o = ent_q;

endmodule

[hw/rtl/arp_resolution_cache.sv]
// ----------------------------------------------------------------------------
// arp_resolution_cache
// ARP resolution table with a queue of handles waiting for a MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: an outbound
//   packet, a received ARP packet or a time tick (func_i). Results leave on
//   out_valid_o / out_stall_i, last_o marks the final result of an item.
//   Configuration registers are written over cfg_valid_i / cfg_ready_o,
//   always ready; write only while the block is idle.
//   One item at a time: the input stalls from accept until the item is done.
//   An item passes through lookup, dispatch and finish states, a received
//   ARP also through the answer state; a tick scans every entry in turn and
//   a drain walks the queued-handle chain. A stalled receiver holds the
//   output register and freezes the sequencer until the result is taken.
//   Reset clears the table valid bits, queue fill count and the time base;
//   registers return to their reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_resolution_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] packet_handle_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  input  logic        target_routable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] out_handle_o,
  output logic [47:0] out_mac_o,
  output logic [31:0] out_ip_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned EW  = arc_pkg::EW;
  localparam int unsigned PW  = arc_pkg::PW;
  localparam int unsigned PCW = arc_pkg::PCW;
  localparam int unsigned NE  = arc_pkg::ENTRIES;
  localparam int unsigned NP  = arc_pkg::POOL;

  // configuration
  logic [31:0] own_ip_q, cache_to_q;
  logic [47:0] own_mac_q;
  logic [15:0] retry_to_q;
  logic [7:0]  retry_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q    <= '0;
      own_mac_q   <= '0;
      retry_to_q  <= 16'd1000;
      retry_lim_q <= 8'd3;
      cache_to_q  <= 32'd120000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        arc_pkg::REG_OWN_IP:        own_ip_q    <= cfg_data_i[31:0];
        arc_pkg::REG_OWN_MAC:       own_mac_q   <= cfg_data_i;
        arc_pkg::REG_RETRY_TIMEOUT: retry_to_q  <= cfg_data_i[15:0];
        arc_pkg::REG_RETRY_LIMIT:   retry_lim_q <= cfg_data_i[7:0];
        arc_pkg::REG_CACHE_TIMEOUT: cache_to_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // latched item
  arc_pkg::func_e func_q;
  logic [15:0] handle_q, op_q;
  logic [31:0] key_q, sip_q;
  logic [47:0] smac_q;
  logic        rec_q;

  // table
  logic          ent_valid_q [NE];
  logic          ent_pend_q  [NE];
  logic [31:0]   ent_ip_q    [NE];
  logic [47:0]   ent_mac_q   [NE];
  logic [7:0]    ent_ret_q   [NE];
  logic [31:0]   ent_stamp_q [NE];
  logic [31:0]   ent_dead_q  [NE];
  logic [31:0]   now_q;

  arc_pkg::state_e state_q, state_d, ret_q;
  logic [EW-1:0] idx_q, own_q;
  logic          hit_q, free_ok_q;
  logic [PCW-1:0] cnt_q, drn_q;
  arc_pkg::kind_e dkind_q;
  logic [47:0]    dmac_q;

  // output register and one-deep hold for the last flag
  logic        out_v_q, hold_v_q;
  logic [2:0]  out_kind_q, hold_kind_q;
  logic [15:0] out_hdl_q, hold_hdl_q;
  logic [47:0] out_mac_q, hold_mac_q;
  logic [31:0] out_ip_q, hold_ip_q;
  logic        out_last_q;

  // lookup
  logic          hit_c, free_c;
  logic [EW-1:0] hit_idx_c, free_idx_c;

  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_idx_c = '0;
    free_idx_c = '0;
    for (int i = NE - 1; i >= 0; i--) begin
      if (ent_valid_q[i] && ent_ip_q[i] == key_q) begin
        hit_c = 1'b1;
        hit_idx_c = EW'(i);
      end
      if (!ent_valid_q[i]) begin
        free_c = 1'b1;
        free_idx_c = EW'(i);
      end
    end
  end

  // queued-handle chain
  arc_pkg::pool_ctl_t pctl [NP];
  arc_pkg::pool_ent_t pq   [NP];
  arc_pkg::pool_ent_t pnb  [NP];
  arc_pkg::pool_ent_t pwr;
  logic enq, rm;

  assign pwr.handle = handle_q;
  assign pwr.owner  = idx_q;

  for (genvar j = 0; j < NP; j++) begin : g_pool
    if (j == NP - 1) begin : g_end
      assign pnb[j] = pq[j];
    end else begin : g_mid
      assign pnb[j] = pq[j + 1];
    end
    assign pctl[j].load  = enq && (cnt_q == PCW'(j));
    assign pctl[j].shift = rm && (drn_q <= PCW'(j));
    arc_pool_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (pctl[j]),
      .wr_i   (pwr),
      .nb_i   (pnb[j]),
      .q_o    (pq[j])
    );
  end

  // selected entry
  logic        s_valid, s_pend, stale, full, go, due, last_ent, lim_ok;
  logic [31:0] s_ip, s_stamp, s_dead, to_ticks, dead_new;
  logic [47:0] s_mac;
  logic [7:0]  r1;
  logic [7:0]  s_ret_plus;
  arc_pkg::pool_ent_t dq;

  assign s_valid  = ent_valid_q[idx_q];
  assign s_pend   = ent_pend_q[idx_q];
  assign s_ip     = ent_ip_q[idx_q];
  assign s_mac    = ent_mac_q[idx_q];
  assign s_stamp  = ent_stamp_q[idx_q];
  assign s_dead   = ent_dead_q[idx_q];
  assign stale    = (now_q - s_stamp) > cache_to_q;
  assign full     = cnt_q >= PCW'(NP);
  assign go       = !out_v_q || !out_stall_i;
  assign to_ticks = (retry_to_q == 16'd0) ? 32'd1 : {16'd0, retry_to_q};
  assign dead_new = now_q + to_ticks;
  assign due      = s_valid && s_pend && (s_dead == now_q);
  assign s_ret_plus = ent_ret_q[idx_q] + 8'd1;
  assign r1       = s_ret_plus;
  assign lim_ok   = r1 < retry_lim_q;
  assign last_ent = idx_q == EW'(NE - 1);
  assign dq       = pq[drn_q[PW-1:0]];

  // sequencer
  logic        emit, flush;
  logic [2:0]  e_kind;
  logic [15:0] e_hdl;
  logic [47:0] e_mac;
  logic [31:0] e_ip;
  logic        ent_new, ent_start, ent_upd, ent_tick, ent_fail, go_drain;

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    flush     = 1'b0;
    e_kind    = arc_pkg::KIND_SEND;
    e_hdl     = '0;
    e_mac     = '0;
    e_ip      = '0;
    enq       = 1'b0;
    rm        = 1'b0;
    ent_new   = 1'b0;
    ent_start = 1'b0;
    ent_upd   = 1'b0;
    ent_tick  = 1'b0;
    ent_fail  = 1'b0;
    go_drain  = 1'b0;
    unique case (state_q)
      arc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = arc_pkg::ST_LOOKUP;
      end
      arc_pkg::ST_LOOKUP: state_d = arc_pkg::ST_DISPATCH;
      arc_pkg::ST_DISPATCH: begin
        if (go) begin
          state_d = arc_pkg::ST_FINISH;
          case (func_q)
            arc_pkg::FUNC_OUTBOUND: begin
              emit = 1'b1;
              e_hdl = handle_q;
              if (!hit_q && (!free_ok_q || full)) begin
                e_kind = arc_pkg::KIND_FULL;
              end else if (!hit_q) begin
                e_kind = arc_pkg::KIND_REQ;
                e_hdl = '0;
                e_mac = arc_pkg::BCAST_MAC;
                e_ip = key_q;
                ent_new = 1'b1;
                ent_start = 1'b1;
                enq = 1'b1;
              end else if (s_pend) begin
                if (full) begin
                  e_kind = arc_pkg::KIND_FULL;
                end else begin
                  emit = 1'b0;
                  enq = 1'b1;
                end
              end else if (stale) begin
                if (full) begin
                  e_kind = arc_pkg::KIND_FULL;
                end else begin
                  e_kind = arc_pkg::KIND_REQ;
                  e_hdl = '0;
                  e_mac = arc_pkg::BCAST_MAC;
                  e_ip = s_ip;
                  ent_start = 1'b1;
                  enq = 1'b1;
                end
              end else begin
                e_kind = arc_pkg::KIND_SEND;
                e_mac = s_mac;
              end
            end
            arc_pkg::FUNC_RECEIVED: begin
              if (hit_q) begin
                ent_upd = 1'b1;
                go_drain = 1'b1;
                state_d = arc_pkg::ST_DRAIN;
              end else begin
                // learn only when aimed at us or routable
                if (rec_q && free_ok_q) begin
                  ent_new = 1'b1;
                  ent_upd = 1'b1;
                end
                state_d = arc_pkg::ST_RX_ANSWER;
              end
            end
            arc_pkg::FUNC_TICK: state_d = arc_pkg::ST_TICK_SCAN;
            default: ;
          endcase
        end
      end
      arc_pkg::ST_RX_ANSWER: begin
        if (go) begin
          state_d = arc_pkg::ST_FINISH;
          if (rec_q && op_q == arc_pkg::OP_REQUEST) begin
            emit = 1'b1;
            e_kind = arc_pkg::KIND_REPLY;
            e_mac = smac_q;
            e_ip = sip_q;
          end else if (rec_q && op_q != arc_pkg::OP_REPLY) begin
            emit = 1'b1;
            e_kind = arc_pkg::KIND_FULL;
          end
        end
      end
      arc_pkg::ST_TICK_SCAN: begin
        if (go) begin
          state_d = last_ent ? arc_pkg::ST_FINISH : arc_pkg::ST_TICK_SCAN;
          if (due) begin
            ent_tick = 1'b1;
            if (lim_ok) begin
              emit = 1'b1;
              e_kind = arc_pkg::KIND_REQ;
              e_mac = arc_pkg::BCAST_MAC;
              e_ip = s_ip;
            end else begin
              ent_fail = 1'b1;
              go_drain = 1'b1;
              state_d = arc_pkg::ST_DRAIN;
            end
          end
        end
      end
      arc_pkg::ST_DRAIN: begin
        if (go) begin
          if (drn_q >= cnt_q) begin
            state_d = ret_q;
          end else if (dq.owner == own_q) begin
            emit = 1'b1;
            e_kind = dkind_q;
            e_hdl = dq.handle;
            e_mac = dmac_q;
            rm = 1'b1;
          end
        end
      end
      arc_pkg::ST_FINISH: begin
        if (go) begin
          flush = hold_v_q;
          state_d = arc_pkg::ST_IDLE;
        end
      end
      default: state_d = arc_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = state_q != arc_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      cnt_q    <= '0;
      drn_q    <= '0;
      idx_q    <= '0;
      own_q    <= '0;
      hit_q    <= 1'b0;
      free_ok_q <= 1'b0;
      ret_q    <= arc_pkg::ST_FINISH;
      dkind_q  <= arc_pkg::KIND_SEND;
      func_q   <= arc_pkg::FUNC_NONE;
      for (int i = 0; i < NE; i++) begin
        ent_valid_q[i] <= 1'b0;
        ent_pend_q[i]  <= 1'b0;
      end
    end else begin
      if (state_q == arc_pkg::ST_IDLE && in_valid_i) begin
        func_q <= arc_pkg::func_e'(func_i);
      end
      if (state_q == arc_pkg::ST_LOOKUP) begin
        hit_q     <= hit_c;
        free_ok_q <= free_c;
        idx_q     <= hit_c ? hit_idx_c : free_idx_c;
      end
      if (state_q == arc_pkg::ST_DISPATCH && go && func_q == arc_pkg::FUNC_TICK) begin
        now_q <= now_q + 32'd1;
        idx_q <= '0;
      end
      if (state_q == arc_pkg::ST_TICK_SCAN && go && !last_ent) begin
        idx_q <= idx_q + EW'(1);
      end
      if (go_drain) begin
        own_q   <= idx_q;
        drn_q   <= '0;
        dkind_q <= ent_fail ? arc_pkg::KIND_FAIL : arc_pkg::KIND_SEND;
        if (ent_fail) begin
          ret_q <= last_ent ? arc_pkg::ST_FINISH : arc_pkg::ST_TICK_SCAN;
        end else begin
          ret_q <= arc_pkg::ST_RX_ANSWER;
        end
      end else if (state_q == arc_pkg::ST_DRAIN && go && !rm && drn_q < cnt_q) begin
        drn_q <= drn_q + PCW'(1);
      end
      if (enq) cnt_q <= cnt_q + PCW'(1);
      if (rm)  cnt_q <= cnt_q - PCW'(1);
      if (ent_new) begin
        ent_valid_q[idx_q] <= 1'b1;
      end
      if (ent_start) begin
        ent_pend_q[idx_q] <= 1'b1;
      end
      if (ent_upd) begin
        ent_pend_q[idx_q] <= 1'b0;
      end
      if (ent_fail) begin
        ent_valid_q[idx_q] <= 1'b0;
        ent_pend_q[idx_q]  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == arc_pkg::ST_IDLE && in_valid_i) begin
      handle_q <= packet_handle_i;
      key_q    <= (func_i == arc_pkg::FUNC_RECEIVED) ? sender_ip_i :
                  (next_hop_ip_i != 32'd0) ? next_hop_ip_i : dest_ip_i;
      op_q     <= arp_opcode_i;
      smac_q   <= sender_mac_i;
      sip_q    <= sender_ip_i;
      rec_q    <= (target_ip_i == own_ip_q) || target_routable_i;
    end
    if (go_drain) begin
      dmac_q <= ent_fail ? 48'd0 : smac_q;
    end
    if (ent_new) begin
      ent_ip_q[idx_q] <= key_q;
      // a learned entry takes the sender MAC below
      if (!ent_upd) ent_mac_q[idx_q] <= '0;
    end
    if (ent_start) begin
      ent_ret_q[idx_q]   <= '0;
      ent_stamp_q[idx_q] <= '0;
      ent_dead_q[idx_q]  <= dead_new;
    end
    if (ent_upd) begin
      ent_ret_q[idx_q]   <= '0;
      ent_mac_q[idx_q]   <= smac_q;
      ent_stamp_q[idx_q] <= now_q;
    end
    if (ent_tick) begin
      ent_ret_q[idx_q] <= r1;
      if (lim_ok) ent_dead_q[idx_q] <= dead_new;
    end
    if (emit) begin
      hold_kind_q <= e_kind;
      hold_hdl_q  <= e_hdl;
      hold_mac_q  <= e_mac;
      hold_ip_q   <= e_ip;
    end
    if (flush || (emit && hold_v_q)) begin
      out_kind_q <= hold_kind_q;
      out_hdl_q  <= hold_hdl_q;
      out_mac_q  <= hold_mac_q;
      out_ip_q   <= hold_ip_q;
      out_last_q <= flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      if (flush || (emit && hold_v_q)) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (emit) begin
        hold_v_q <= 1'b1;
      end else if (flush) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign kind_o       = out_kind_q;
  assign out_handle_o = out_hdl_q;
  assign out_mac_o    = out_mac_q;
  assign out_ip_o     = out_ip_q;
  assign last_o       = out_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PCW'(NP))
    else $error("queue count beyond pool size");

  a_no_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |-> !full)
    else $error("enqueue into full queue");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == arc_pkg::ST_IDLE |-> !hold_v_q)
    else $error("result held across items");

  a_emit_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit || flush) |-> (!out_v_q || !out_stall_i))
    else $error("output overwritten while stalled");

endmodule

[bench/arp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_checker
// Watches the item, result and register channels of the ARP resolution
// cache, predicts every result from its own copy of the table and queue,
// and compares the results as they arrive.
// ----------------------------------------------------------------------------
module arp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [15:0] packet_handle_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  input  logic        target_routable_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [15:0] out_handle_i,
  input  logic [47:0] out_mac_i,
  input  logic [31:0] out_ip_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        last;
  } arp_result_t;

  arp_result_t expected_q[$];
  arp_result_t batch_q[$];

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] retry_timeout;
  logic [7:0]  retry_limit;
  logic [31:0] cache_timeout;

  logic [31:0] now;
  logic        tbl_valid    [arc_pkg::ENTRIES];
  logic [31:0] tbl_ip       [arc_pkg::ENTRIES];
  logic [47:0] tbl_mac      [arc_pkg::ENTRIES];
  logic        tbl_pending  [arc_pkg::ENTRIES];
  logic [7:0]  tbl_retries  [arc_pkg::ENTRIES];
  logic [31:0] tbl_stamp    [arc_pkg::ENTRIES];
  logic [31:0] tbl_deadline [arc_pkg::ENTRIES];
  logic [15:0] q_handle     [arc_pkg::POOL];
  int          q_owner      [arc_pkg::POOL];
  int          q_count;

  assign pending_o = expected_q.size();

  function automatic void emit(logic [2:0] kind, logic [15:0] handle, logic [47:0] mac,
                               logic [31:0] ip);
    arp_result_t r;
    r.kind = kind;
    r.handle = handle;
    r.mac = mac;
    r.ip = ip;
    r.last = 1'b0;
    if (batch_q.size() < 24) batch_q.insert(batch_q.size(), r);
  endfunction

  function automatic int lookup(logic [31:0] ip);
    for (int i = 0; i < arc_pkg::ENTRIES; i++)
      if (tbl_valid[i] && tbl_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < arc_pkg::ENTRIES; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  function automatic logic [31:0] retry_ticks();
    return (retry_timeout == 16'd0) ? 32'd1 : {16'd0, retry_timeout};
  endfunction

  // flush every queued handle of one entry, keeping the order of the rest
  function automatic void flush_queue(int e, logic [2:0] kind, logic [47:0] mac);
    int keep;
    keep = 0;
    for (int i = 0; i < q_count; i++) begin
      if (q_owner[i] == e) begin
        emit(kind, q_handle[i], mac, 32'd0);
      end else begin
        q_handle[keep] = q_handle[i];
        q_owner[keep] = q_owner[i];
        keep++;
      end
    end
    q_count = keep;
  endfunction

  function automatic void enqueue(int e, logic [15:0] handle);
    q_handle[q_count] = handle;
    q_owner[q_count] = e;
    q_count++;
  endfunction

  function automatic void send_request(int e);
    tbl_pending[e] = 1'b1;
    tbl_retries[e] = 8'd0;
    tbl_stamp[e] = 32'd0;
    tbl_deadline[e] = now + retry_ticks();
    emit(arc_pkg::KIND_REQ, 16'd0, arc_pkg::BCAST_MAC, tbl_ip[e]);
  endfunction

  function automatic void resolve(int e, logic [47:0] mac);
    tbl_pending[e] = 1'b0;
    tbl_retries[e] = 8'd0;
    tbl_mac[e] = mac;
    tbl_stamp[e] = now;
    flush_queue(e, arc_pkg::KIND_SEND, mac);
  endfunction

  function automatic void predict_outbound();
    logic [31:0] ip;
    logic        full;
    int          e;
    int          f;
    ip = (next_hop_ip_i != 32'd0) ? next_hop_ip_i : dest_ip_i;
    full = q_count >= arc_pkg::POOL;
    e = lookup(ip);
    if (e < 0) begin
      f = free_slot();
      if (f < 0 || full) begin
        emit(arc_pkg::KIND_FULL, packet_handle_i, 48'd0, 32'd0);
      end else begin
        tbl_valid[f] = 1'b1;
        tbl_ip[f] = ip;
        tbl_mac[f] = 48'd0;
        send_request(f);
        enqueue(f, packet_handle_i);
      end
    end else if (tbl_pending[e]) begin
      if (full) emit(arc_pkg::KIND_FULL, packet_handle_i, 48'd0, 32'd0);
      else enqueue(e, packet_handle_i);
    end else if (now - tbl_stamp[e] > cache_timeout) begin
      if (full) begin
        emit(arc_pkg::KIND_FULL, packet_handle_i, 48'd0, 32'd0);
      end else begin
        send_request(e);
        enqueue(e, packet_handle_i);
      end
    end else begin
      emit(arc_pkg::KIND_SEND, packet_handle_i, tbl_mac[e], 32'd0);
    end
  endfunction

  function automatic void predict_received();
    int e;
    int f;
    e = lookup(sender_ip_i);
    if (e >= 0) resolve(e, sender_mac_i);
    if (!(target_ip_i == own_ip || target_routable_i)) return;
    if (e < 0) begin
      f = free_slot();
      if (f >= 0) begin
        tbl_valid[f] = 1'b1;
        tbl_ip[f] = sender_ip_i;
        tbl_pending[f] = 1'b0;
        resolve(f, sender_mac_i);
      end
    end
    if (arp_opcode_i == arc_pkg::OP_REQUEST)
      emit(arc_pkg::KIND_REPLY, 16'd0, sender_mac_i, sender_ip_i);
    else if (arp_opcode_i != arc_pkg::OP_REPLY)
      emit(arc_pkg::KIND_FULL, 16'd0, 48'd0, 32'd0);
  endfunction

  function automatic void predict_tick();
    now++;
    for (int e = 0; e < arc_pkg::ENTRIES; e++) begin
      if (tbl_valid[e] && tbl_pending[e] && tbl_deadline[e] == now) begin
        tbl_retries[e] = tbl_retries[e] + 8'd1;
        if (tbl_retries[e] < retry_limit) begin
          tbl_deadline[e] = now + retry_ticks();
          emit(arc_pkg::KIND_REQ, 16'd0, arc_pkg::BCAST_MAC, tbl_ip[e]);
        end else begin
          flush_queue(e, arc_pkg::KIND_FAIL, 48'd0);
          tbl_valid[e] = 1'b0;
          tbl_pending[e] = 1'b0;
        end
      end
    end
  endfunction

  function automatic void predict_item();
    batch_q.delete();
    case (arc_pkg::func_e'(func_i))
      arc_pkg::FUNC_OUTBOUND: predict_outbound();
      arc_pkg::FUNC_RECEIVED: predict_received();
      arc_pkg::FUNC_TICK:     predict_tick();
      default: ;
    endcase
    if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
    foreach (batch_q[i]) expected_q.insert(expected_q.size(), batch_q[i]);
  endfunction

  function automatic void check_result();
    arp_result_t x;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind %0d handle %h", $time, kind_i, out_handle_i);
      fail_count_o++;
      return;
    end
    x = expected_q.pop_front();
    if (kind_i != x.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, x.kind, kind_i);
      fail_count_o++;
    end
    if (out_handle_i != x.handle) begin
      $display("%0t: handle expected %h actual %h", $time, x.handle, out_handle_i);
      fail_count_o++;
    end
    if (out_mac_i != x.mac) begin
      $display("%0t: mac expected %h actual %h", $time, x.mac, out_mac_i);
      fail_count_o++;
    end
    if (out_ip_i != x.ip) begin
      $display("%0t: ip expected %h actual %h", $time, x.ip, out_ip_i);
      fail_count_o++;
    end
    if (last_i != x.last) begin
      $display("%0t: last expected %b actual %b", $time, x.last, last_i);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip <= 32'd0;
      own_mac <= 48'd0;
      retry_timeout <= 16'd1000;
      retry_limit <= 8'd3;
      cache_timeout <= 32'd120000;
      now <= 32'd0;
      q_count <= 0;
      for (int i = 0; i < arc_pkg::ENTRIES; i++) begin
        tbl_valid[i] <= 1'b0;
        tbl_pending[i] <= 1'b0;
      end
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (arc_pkg::reg_e'(cfg_index_i))
          arc_pkg::REG_OWN_IP:        own_ip = cfg_data_i[31:0];
          arc_pkg::REG_OWN_MAC:       own_mac = cfg_data_i;
          arc_pkg::REG_RETRY_TIMEOUT: retry_timeout = cfg_data_i[15:0];
          arc_pkg::REG_RETRY_LIMIT:   retry_limit = cfg_data_i[7:0];
          arc_pkg::REG_CACHE_TIMEOUT: cache_timeout = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_item();
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ARP resolution cache with directed and random items over
// several register settings; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [15:0] packet_handle;
  logic [31:0] next_hop_ip;
  logic [31:0] dest_ip;
  logic [15:0] arp_opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic        target_routable;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind;
  logic [15:0] out_handle;
  logic [47:0] out_mac;
  logic [31:0] out_ip;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  int          fail_count;
  int          pending;
  int          cycles;
  bit          quiet;
  logic [31:0] ip_set [12];
  logic [31:0] cur_own_ip;

  arp_resolution_cache dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .packet_handle_i(packet_handle),
    .next_hop_ip_i(next_hop_ip), .dest_ip_i(dest_ip),
    .arp_opcode_i(arp_opcode), .sender_mac_i(sender_mac),
    .sender_ip_i(sender_ip), .target_ip_i(target_ip),
    .target_routable_i(target_routable),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .out_handle_o(out_handle), .out_mac_o(out_mac),
    .out_ip_o(out_ip), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  arp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .packet_handle_i(packet_handle),
    .next_hop_ip_i(next_hop_ip), .dest_ip_i(dest_ip),
    .arp_opcode_i(arp_opcode), .sender_mac_i(sender_mac),
    .sender_ip_i(sender_ip), .target_ip_i(target_ip),
    .target_routable_i(target_routable),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .out_handle_i(out_handle), .out_mac_i(out_mac),
    .out_ip_i(out_ip), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom(), 16'($urandom())};
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom());
  endfunction

  function automatic logic rand1();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 19) == 0) ? $urandom() : ip_set[$urandom_range(0, 11)];
  endfunction

  // present one item, hold it until accepted, then maybe idle a while
  task automatic send(arc_pkg::func_e f, logic [15:0] h, logic [31:0] nh,
                      logic [31:0] dst, logic [15:0] op, logic [47:0] smac,
                      logic [31:0] sip, logic [31:0] tip, logic rt);
    in_valid <= 1'b1;
    func <= f;
    packet_handle <= h;
    next_hop_ip <= nh;
    dest_ip <= dst;
    arp_opcode <= op;
    sender_mac <= smac;
    sender_ip <= sip;
    target_ip <= tip;
    target_routable <= rt;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_outbound(logic [15:0] h, logic [31:0] nh, logic [31:0] dst);
    send(arc_pkg::FUNC_OUTBOUND, h, nh, dst, rand16(), rand48(), $urandom(), $urandom(),
         rand1());
  endtask

  task automatic send_arp(logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                          logic [31:0] tip, logic rt);
    send(arc_pkg::FUNC_RECEIVED, rand16(), $urandom(), $urandom(), op, smac, sip, tip, rt);
  endtask

  task automatic send_tick();
    send(arc_pkg::FUNC_TICK, rand16(), $urandom(), $urandom(), rand16(), rand48(),
         $urandom(), $urandom(), rand1());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(arc_pkg::reg_e idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [31:0] oip, logic [47:0] omac, logic [15:0] rto,
                           logic [7:0] rlim, logic [31:0] cto);
    wait_idle();
    write_reg(arc_pkg::REG_OWN_IP, {16'd0, oip});
    write_reg(arc_pkg::REG_OWN_MAC, omac);
    write_reg(arc_pkg::REG_RETRY_TIMEOUT, {32'd0, rto});
    write_reg(arc_pkg::REG_RETRY_LIMIT, {40'd0, rlim});
    write_reg(arc_pkg::REG_CACHE_TIMEOUT, {16'd0, cto});
    cfg_valid <= 1'b0;
    cur_own_ip = oip;
  endtask

  task automatic random_items(int n);
    int r;
    logic [15:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 3) == 0) send_outbound(rand16(), 32'd0, pick_ip());
        else send_outbound(rand16(), pick_ip(), $urandom());
      end else if (r < 75) begin
        case ($urandom_range(0, 4))
          0, 1:    op = arc_pkg::OP_REQUEST;
          2, 3:    op = arc_pkg::OP_REPLY;
          default: op = rand16();
        endcase
        send_arp(op, rand48(), pick_ip(),
                 ($urandom_range(0, 4) < 3) ? cur_own_ip : $urandom(),
                 rand1());
      end else if (r < 97) begin
        send_tick();
      end else begin
        send(arc_pkg::FUNC_NONE, rand16(), $urandom(), $urandom(), rand16(), rand48(),
             $urandom(), $urandom(), rand1());
      end
    end
  endtask

  initial begin
    cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = arc_pkg::FUNC_NONE;
    packet_handle = '0;
    next_hop_ip = '0;
    dest_ip = '0;
    arp_opcode = '0;
    sender_mac = '0;
    sender_ip = '0;
    target_ip = '0;
    target_routable = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = arc_pkg::REG_OWN_IP;
    cfg_data = '0;
    cur_own_ip = '0;
    foreach (ip_set[i]) ip_set[i] = $urandom();
    ip_set[11] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: miss, queue, resolve, reply, proxy, bad opcode, retry, stale
    configure(32'h0A00_0001, 48'h0200_0000_0001, 16'd2, 8'd2, 32'd5);
    send_outbound(16'h0000, ip_set[0], 32'd0);
    send_outbound(16'hFFFF, ip_set[0], 32'hFFFF_FFFF);
    send_outbound(16'h1234, 32'd0, ip_set[1]);
    send_arp(arc_pkg::OP_REPLY, 48'hFFFF_FFFF_FFFF, ip_set[0], cur_own_ip, 1'b0);
    send_outbound(16'h0042, ip_set[0], 32'd0);
    send_arp(arc_pkg::OP_REQUEST, 48'h0000_0000_0000, ip_set[2], cur_own_ip, 1'b0);
    send_arp(arc_pkg::OP_REQUEST, rand48(), ip_set[3], 32'hFFFF_FFFF, 1'b0);
    send_arp(16'hFFFF, rand48(), ip_set[3], 32'd0, 1'b1);
    send_arp(16'd0, rand48(), ip_set[4], cur_own_ip, 1'b0);
    send(arc_pkg::FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
         48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    repeat (7) send_tick();
    send_outbound(16'h5555, ip_set[0], 32'd0);
    send_arp(arc_pkg::OP_REPLY, rand48(), ip_set[0], 32'd0, 1'b0);
    send_outbound(16'hAAAA, ip_set[0], 32'd0);

    configure(32'h0A00_0001, 48'h0200_0000_0001, 16'd3, 8'd2, 32'd20);
    random_items(35);
    configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    random_items(35);
    configure(32'd0, 48'd0, 16'd1, 8'd1, 32'd1);
    random_items(35);
    configure(ip_set[5], rand48(), 16'($urandom_range(2, 8)), 8'($urandom_range(1, 4)),
              32'($urandom_range(3, 50)));
    random_items(35);
    configure(ip_set[6], rand48(), 16'($urandom_range(1, 4)), 8'($urandom_range(2, 3)),
              32'($urandom_range(5, 30)));
    quiet = 1'b1;
    random_items(35);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
